// File: rtl/sorted_list_engine_assert.svh
// Assertion macros used by the sorted list engine back end (sle_back).
`ifndef SORTED_LIST_ENGINE_ASSERT_SVH
`define SORTED_LIST_ENGINE_ASSERT_SVH

// Check cond at every clock edge outside reset.
`define SLE_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("sorted list engine: invariant violated");

// Check that cons holds whenever ante holds.
`define SLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list engine: implication violated");

`endif

// File: rtl/sle_pkg.sv
package sle_pkg;

    localparam int ACT_W  = 3;
    localparam int VAL_W  = 16;
    localparam int IDX_W  = 5;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 6;
    localparam int KIND_W = 3;

    localparam logic [ACT_W-1:0] ACT_PUSH_FRONT    = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SORTED_INSERT = 3'd1;
    localparam logic [ACT_W-1:0] ACT_POP_FRONT     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE_ALL    = 3'd3;
    localparam logic [ACT_W-1:0] ACT_CLEAR         = 3'd4;
    localparam logic [ACT_W-1:0] ACT_READ_AT       = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NOP      = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SHIFT_IN = 3'd1;
    localparam logic [KIND_W-1:0] KIND_COMPACT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_READ     = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0]       kind;
        logic                    sorted;
        logic                    drop_head;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        index;
    } t_cmd;

endpackage

// File: rtl/sorted_list_engine.sv
// Sorted list engine: keeps an ordered list of up to CAPACITY signed 16-bit
// values in a single list memory (one write and one registered read port).
// A request passes a decode register and a two-deep queue, then executes in
// the list sequencer, which walks the memory one entry per cycle. Push-front
// and sorted insert walk any existing entries and then write the last entry;
// pop-front and remove-all walk the list once; clear, refused inserts and
// out-of-range reads need no memory access; an in-range read does one
// registered memory read. Each request returns one result transaction. The
// list memory is not cleared at reset; the length register is, so the list starts empty.
module sorted_list_engine
    import sle_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [ACT_W-1:0]        i_action,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [IDX_W-1:0]        i_index,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [STAT_W-1:0]       o_status,
    output logic [CNT_W-1:0]        o_count,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic [CNT_W-1:0]        o_removed
);

    logic front_valid;
    logic front_stall;
    t_cmd front_cmd;
    logic queue_valid;
    logic queue_stall;
    t_cmd queue_cmd;

    sle_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_action (i_action),
        .i_value  (i_value),
        .i_index  (i_index),
        .o_valid  (front_valid),
        .o_cmd    (front_cmd),
        .i_stall  (front_stall)
    );

    sle_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_stall (front_stall),
        .i_cmd   (front_cmd),
        .o_valid (queue_valid),
        .o_cmd   (queue_cmd),
        .i_stall (queue_stall)
    );

    sle_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (queue_valid),
        .o_stall      (queue_stall),
        .i_cmd        (queue_cmd),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_status     (o_status),
        .o_count      (o_count),
        .o_read_value (o_read_value),
        .o_removed    (o_removed)
    );

endmodule

// File: rtl/sle_front.sv
module sle_front
    import sle_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [ACT_W-1:0]        i_action,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [IDX_W-1:0]        i_index,
    output logic                    o_valid,
    output t_cmd                    o_cmd,
    input  logic                    i_stall
);

    logic r_valid;
    logic n_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_stall = r_valid & i_stall;
    assign accept  = i_valid & ~o_stall;
    assign n_valid = accept | (r_valid & i_stall);
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_cmd           = '0;
        n_cmd.value     = i_value;
        n_cmd.index     = i_index;
        unique case (i_action)
            ACT_PUSH_FRONT: begin
                n_cmd.kind = KIND_SHIFT_IN;
            end
            ACT_SORTED_INSERT: begin
                n_cmd.kind   = KIND_SHIFT_IN;
                n_cmd.sorted = 1'b1;
            end
            ACT_POP_FRONT: begin
                n_cmd.kind      = KIND_COMPACT;
                n_cmd.drop_head = 1'b1;
            end
            ACT_REMOVE_ALL: begin
                n_cmd.kind = KIND_COMPACT;
            end
            ACT_CLEAR: begin
                n_cmd.kind = KIND_CLEAR;
            end
            ACT_READ_AT: begin
                n_cmd.kind = KIND_READ;
            end
            default: begin
                n_cmd.kind = KIND_NOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: rtl/sle_queue.sv
module sle_queue
    import sle_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_cmd i_cmd,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_stall
);

    t_cmd       r_slot [2];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    logic       r_wptr;
    logic       r_rptr;
    logic       push;
    logic       pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_slot[r_rptr];
    assign push    = i_valid & ~o_stall;
    assign pop     = o_valid & ~i_stall;

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/sle_back.sv
`include "sorted_list_engine_assert.svh"

module sle_back
    import sle_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  t_cmd                    i_cmd,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic [STAT_W-1:0]       o_status,
    output logic [CNT_W-1:0]        o_count,
    output logic signed [VAL_W-1:0] o_read_value,
    output logic [CNT_W-1:0]        o_removed
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = $clog2(CAPACITY + 1);
    localparam int XW = (LW > IDX_W) ? LW : IDX_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_TAIL  = 3'd2;
    localparam logic [2:0] S_UP    = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;

    logic signed [VAL_W-1:0] r_mem [CAPACITY];
    logic signed [VAL_W-1:0] r_rdata;
    logic                    mem_we;
    logic [AW-1:0]           mem_waddr;
    logic signed [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]           mem_raddr;

    logic [2:0]              r_state, n_state;
    logic [LW-1:0]           r_len, n_len;
    logic [LW-1:0]           r_rem, n_rem;
    logic [AW-1:0]           r_pa, n_pa;
    logic [AW-1:0]           r_wp, n_wp;
    t_cmd                    r_cmd, n_cmd;
    logic signed [VAL_W-1:0] r_carry, n_carry;
    logic                    r_ins, n_ins;

    logic                    r_out_valid, n_out_valid;
    logic [STAT_W-1:0]       r_out_status, n_out_status;
    logic [CNT_W-1:0]        r_out_count, n_out_count;
    logic signed [VAL_W-1:0] r_out_read, n_out_read;
    logic [CNT_W-1:0]        r_out_removed, n_out_removed;

    logic                    out_free;
    logic                    start;
    logic                    fin;
    logic [STAT_W-1:0]       fin_status;
    logic signed [VAL_W-1:0] fin_read;
    logic [LW-1:0]           fin_removed;
    logic                    drop;

    assign out_free = ~r_out_valid | ~i_stall;
    assign start    = (r_state == S_IDLE) & i_valid & out_free;
    assign o_stall  = ~start;

    assign o_valid      = r_out_valid;
    assign o_status     = r_out_status;
    assign o_count      = r_out_count;
    assign o_read_value = r_out_read;
    assign o_removed    = r_out_removed;

    always_comb begin
        n_state       = r_state;
        n_len         = r_len;
        n_rem         = r_rem;
        n_pa          = r_pa;
        n_wp          = r_wp;
        n_cmd         = r_cmd;
        n_carry       = r_carry;
        n_ins         = r_ins;
        n_out_valid   = r_out_valid & i_stall;
        n_out_status  = r_out_status;
        n_out_count   = r_out_count;
        n_out_read    = r_out_read;
        n_out_removed = r_out_removed;
        mem_we        = 1'b0;
        mem_waddr     = r_pa;
        mem_wdata     = r_rdata;
        mem_raddr     = r_pa;
        fin           = 1'b0;
        fin_status    = STAT_OK;
        fin_read      = '0;
        fin_removed   = '0;
        drop          = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    unique case (i_cmd.kind)
                        KIND_SHIFT_IN: begin
                            if (r_len == LW'(CAPACITY)) begin
                                fin        = 1'b1;
                                fin_status = STAT_FULL;
                            end else if (r_len == '0) begin
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = i_cmd.value;
                                n_len     = r_len + LW'(1);
                                fin       = 1'b1;
                            end else begin
                                mem_raddr = '0;
                                n_pa      = '0;
                                n_carry   = i_cmd.value;
                                n_ins     = ~i_cmd.sorted;
                                n_state   = S_SHIFT;
                            end
                        end
                        KIND_COMPACT: begin
                            if (r_len == '0) begin
                                fin        = 1'b1;
                                fin_status = i_cmd.drop_head ? STAT_EMPTY : STAT_OK;
                            end else begin
                                mem_raddr = '0;
                                n_pa      = '0;
                                n_wp      = '0;
                                n_rem     = '0;
                                n_state   = S_UP;
                            end
                        end
                        KIND_CLEAR: begin
                            fin         = 1'b1;
                            fin_removed = r_len;
                            n_len       = '0;
                        end
                        KIND_READ: begin
                            if (XW'(i_cmd.index) < XW'(r_len)) begin
                                mem_raddr = AW'(i_cmd.index);
                                n_state   = S_READ;
                            end else begin
                                fin        = 1'b1;
                                fin_status = STAT_EMPTY;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_ins || !(r_cmd.value > r_rdata)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_pa;
                    mem_wdata = r_carry;
                    n_carry   = r_rdata;
                    n_ins     = 1'b1;
                end
                if (LW'(r_pa) + LW'(1) == r_len) begin
                    n_state = S_TAIL;
                end else begin
                    mem_raddr = r_pa + AW'(1);
                    n_pa      = mem_raddr;
                end
            end
            S_TAIL: begin
                mem_we    = 1'b1;
                mem_waddr = AW'(r_len);
                mem_wdata = r_carry;
                n_len     = r_len + LW'(1);
                fin       = 1'b1;
                n_state   = S_IDLE;
            end
            S_UP: begin
                drop = r_cmd.drop_head ? (r_pa == '0) : (r_rdata == r_cmd.value);
                if (drop) begin
                    n_rem = r_rem + LW'(1);
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = r_wp;
                    mem_wdata = r_rdata;
                    n_wp      = r_wp + AW'(1);
                end
                if (LW'(r_pa) + LW'(1) == r_len) begin
                    n_len       = r_len - n_rem;
                    fin         = 1'b1;
                    fin_removed = n_rem;
                    n_state     = S_IDLE;
                end else begin
                    mem_raddr = r_pa + AW'(1);
                    n_pa      = mem_raddr;
                end
            end
            S_READ: begin
                fin      = 1'b1;
                fin_read = r_rdata;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (fin) begin
            n_out_valid   = 1'b1;
            n_out_status  = fin_status;
            n_out_count   = CNT_W'(n_len);
            n_out_read    = fin_read;
            n_out_removed = CNT_W'(fin_removed);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem         <= n_rem;
        r_pa          <= n_pa;
        r_wp          <= n_wp;
        r_cmd         <= n_cmd;
        r_carry       <= n_carry;
        r_ins         <= n_ins;
        r_out_status  <= n_out_status;
        r_out_count   <= n_out_count;
        r_out_read    <= n_out_read;
        r_out_removed <= n_out_removed;
    end

    `SLE_ASSERT_ALWAYS(a_len_bound, i_clk, i_rst_n, r_len <= LW'(CAPACITY))
    `SLE_ASSERT_IMPLY(a_busy_out_free, i_clk, i_rst_n, r_state != S_IDLE, !r_out_valid)
    `SLE_ASSERT_IMPLY(a_compact_order, i_clk, i_rst_n, r_state == S_UP, r_wp <= r_pa)

endmodule
